/* rtl/core/easing_curve_evaluator_defines.svh */
// Assertion macros used by the core sequencer module (ece_ctrl).
`ifndef EASING_CURVE_EVALUATOR_DEFINES_SVH
`define EASING_CURVE_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define ECE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ece assertion failed");
// ante implies cons in the next cycle
`define ECE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ece assertion failed");
`else
`define ECE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ECE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/ece_pkg.sv */
package ece_pkg;

  // request modes
  localparam logic MODE_PRESET = 1'b0;
  localparam logic MODE_BEZIER = 1'b1;

  // preset curve codes, any other code runs as linear
  localparam logic [2:0] PRESET_LINEAR = 3'd0;
  localparam logic [2:0] PRESET_SMOOTH = 3'd1;
  localparam logic [2:0] PRESET_IN     = 3'd2;
  localparam logic [2:0] PRESET_OUT    = 3'd3;
  localparam logic [2:0] PRESET_INOUT  = 3'd4;

  // operand selects of the shared multiplier
  localparam logic [3:0] SEL_U    = 4'd0;
  localparam logic [3:0] SEL_INV  = 4'd1;
  localparam logic [3:0] SEL_A    = 4'd2;
  localparam logic [3:0] SEL_B    = 4'd3;
  localparam logic [3:0] SEL_C    = 4'd4;
  localparam logic [3:0] SEL_P1   = 4'd5;
  localparam logic [3:0] SEL_P2   = 4'd6;
  localparam logic [3:0] SEL_DIFF = 4'd7;
  localparam logic [3:0] SEL_OMP2 = 4'd8;
  localparam logic [3:0] SEL_T    = 4'd9;
  localparam logic [3:0] SEL_TMP  = 4'd10;
  localparam logic [3:0] SEL_TM   = 4'd11;

  // product destinations
  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_A    = 3'd1;
  localparam logic [2:0] DST_B    = 3'd2;
  localparam logic [2:0] DST_C    = 3'd3;
  localparam logic [2:0] DST_TMP  = 3'd4;

  // result sources
  localparam logic [1:0] RES_ACC = 2'd0;
  localparam logic [1:0] RES_OMA = 2'd1;
  localparam logic [1:0] RES_T   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [3:0] sel_a;
    logic [3:0] sel_b;
    logic [2:0] dst;
    logic       acc_clr;
    logic [2:0] acc_k;
    logic       use_y;
    logic       dx_save;
    logic       div_start;
    logic       u_upd;
    logic       bis_init;
    logic       bis_step;
    logic [1:0] res_mode;
    logic       out_load;
  } ece_cmd_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] kind;
    logic       t_lt_half;
    logic       dx_small;
    logic       res_big;
    logic       div_done;
  } ece_stat_t;

  localparam ece_cmd_t CMD_IDLE = '{default: '0};

  // one phase of a curve evaluation: a=inv^2, b=inv*u, c=u^2, slope, then x (or y)
  function automatic ece_cmd_t eval_cmd(input logic [3:0] ph);
    ece_cmd_t c;
    c = CMD_IDLE;
    c.mul_en = 1'b1;
    case (ph)
      4'd0: begin c.sel_a = SEL_INV; c.sel_b = SEL_INV; c.dst = DST_A; end
      4'd1: begin c.sel_a = SEL_INV; c.sel_b = SEL_U; c.dst = DST_B; end
      4'd2: begin c.sel_a = SEL_U; c.sel_b = SEL_U; c.dst = DST_C; end
      4'd3: begin c.sel_a = SEL_A; c.sel_b = SEL_P1; c.acc_clr = 1'b1; c.acc_k = 3'd3; end
      4'd4: begin c.sel_a = SEL_B; c.sel_b = SEL_DIFF; c.acc_k = 3'd6; end
      4'd5: begin c.sel_a = SEL_C; c.sel_b = SEL_OMP2; c.acc_k = 3'd3; end
      4'd6: begin c.sel_a = SEL_A; c.sel_b = SEL_U; c.dst = DST_TMP; end
      4'd7: begin c.sel_a = SEL_TMP; c.sel_b = SEL_P1; c.acc_clr = 1'b1; c.acc_k = 3'd3; end
      4'd8: begin c.sel_a = SEL_B; c.sel_b = SEL_U; c.dst = DST_TMP; end
      4'd9: begin c.sel_a = SEL_TMP; c.sel_b = SEL_P2; c.acc_k = 3'd3; end
      4'd10: begin c.sel_a = SEL_C; c.sel_b = SEL_U; c.acc_k = 3'd1; end
      default: c.mul_en = 1'b0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/ece_if.sv */
// request channel
interface ece_in_if #(parameter int FRACTION_BITS = 16);
  logic                     valid;
  logic                     ready;
  logic [FRACTION_BITS:0]   progress;
  logic                     mode;
  logic [2:0]               preset_kind;
  logic [FRACTION_BITS:0]   out_x;
  logic [FRACTION_BITS:0]   out_y;
  logic [FRACTION_BITS:0]   in_x;
  logic [FRACTION_BITS:0]   in_y;
  modport source (output valid, progress, mode, preset_kind, out_x, out_y, in_x, in_y,
                  input ready);
  modport sink (input valid, progress, mode, preset_kind, out_x, out_y, in_x, in_y,
                output ready);
endinterface

// result channel
interface ece_out_if #(parameter int FRACTION_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [FRACTION_BITS:0] eased;
  modport source (output valid, eased, input ready);
  modport sink (input valid, eased, output ready);
endinterface

/* rtl/core/ece_div.sv */
// restoring divider, one quotient bit per cycle
module ece_div #(
  parameter int NW = 37,
  parameter int MW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [MW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] d_r, d_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [MW:0]   sh;
  logic          ge;

  assign sh = {rem_r, quo_r[NW-1]};
  assign ge = sh >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      rem_nxt  = '0;
      d_nxt    = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? MW'(sh - {1'b0, d_r}) : sh[MW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quot = quo_r;
endmodule

/* rtl/core/ece_datapath.sv */
// operand registers, shared multiplier, accumulator and the divider
module ece_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ece_pkg::ece_cmd_t      cmd,
  output ece_pkg::ece_stat_t     stat,
  input  logic [FRACTION_BITS:0] progress,
  input  logic                   mode,
  input  logic [2:0]             preset_kind,
  input  logic [FRACTION_BITS:0] out_x,
  input  logic [FRACTION_BITS:0] out_y,
  input  logic [FRACTION_BITS:0] in_x,
  input  logic [FRACTION_BITS:0] in_y,
  output logic [FRACTION_BITS:0] eased
);
  localparam int F   = FRACTION_BITS;
  localparam int VW  = F + 6;
  localparam int MW  = F + 2;
  localparam int NW  = VW - 1 + F;
  localparam int UW  = NW + 2;
  localparam int ONE_I  = 1 << F;
  localparam int DX_EPS_C = ((ONE_I + 5000) / 10000 < 1) ? 1 : (ONE_I + 5000) / 10000;
  localparam int RES_EPS_C = (ONE_I + 500) / 1000;
  localparam logic signed [VW-1:0] ONE = VW'(ONE_I);
  localparam logic [2*MW-1:0] HALF = (2*MW)'(ONE_I / 2);

  typedef logic signed [VW-1:0] val_t;

  val_t t_r, p1x_r, p2x_r, p1y_r, p2y_r, u_r, a_r, b_r, c_r, tmp_r, acc_r, dx_r;
  val_t lo_r, hi_r;
  logic mode_r;
  logic [2:0] kind_r;
  logic sgn_r;
  logic [F:0] eased_r;

  val_t p1, p2, inv, opa, opb, prod, r, err, lo_n, hi_n, res_v;
  logic [VW-1:0] ma_full, mb_full, mdx, merr, mr;
  logic [2*MW-1:0] pfull;
  logic [VW-1:0] pmag;
  logic [NW-1:0] quot;
  logic div_busy;
  logic signed [UW-1:0] uw;

  function automatic val_t rd_unit(input logic [F:0] v);
    return (v > (F+1)'(ONE_I)) ? ONE : VW'(v);
  endfunction

  function automatic logic [VW-1:0] mag(input val_t v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  function automatic val_t clamp1(input val_t v);
    if (v < 0) return '0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  assign p1  = cmd.use_y ? p1y_r : p1x_r;
  assign p2  = cmd.use_y ? p2y_r : p2x_r;
  assign inv = ONE - u_r;

  // operand selection
  function automatic val_t pick(input logic [3:0] s, input val_t uu, input val_t ii,
                                input val_t aa, input val_t bb, input val_t cc,
                                input val_t q1, input val_t q2, input val_t tt,
                                input val_t mm);
    case (s)
      ece_pkg::SEL_U:    return uu;
      ece_pkg::SEL_INV:  return ii;
      ece_pkg::SEL_A:    return aa;
      ece_pkg::SEL_B:    return bb;
      ece_pkg::SEL_C:    return cc;
      ece_pkg::SEL_P1:   return q1;
      ece_pkg::SEL_P2:   return q2;
      ece_pkg::SEL_DIFF: return q2 - q1;
      ece_pkg::SEL_OMP2: return ONE - q2;
      ece_pkg::SEL_T:    return tt;
      ece_pkg::SEL_TMP:  return mm;
      ece_pkg::SEL_TM:   return val_t'(3 * ONE - 2 * tt);
      default:           return '0;
    endcase
  endfunction

  assign opa = pick(cmd.sel_a, u_r, inv, a_r, b_r, c_r, p1, p2, t_r, tmp_r);
  assign opb = pick(cmd.sel_b, u_r, inv, a_r, b_r, c_r, p1, p2, t_r, tmp_r);

  // rounded product on magnitudes, sign reapplied
  assign ma_full = mag(opa);
  assign mb_full = mag(opb);
  assign pfull   = ma_full[MW-1:0] * mb_full[MW-1:0] + HALF;
  assign pmag    = VW'(pfull >> F);
  assign prod    = (opa[VW-1] != opb[VW-1]) ? -val_t'(pmag) : val_t'(pmag);

  // status
  assign r    = acc_r - t_r;
  assign err  = r;
  assign mr   = mag(r);
  assign merr = mag(err);
  assign mdx  = mag(dx_r);

  ece_div #(.NW(NW), .MW(VW - 1)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({merr[VW-2:0], {F{1'b0}}}),
    .divisor  (mdx[VW-2:0]),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign uw = sgn_r ? (UW'(u_r) + $signed({2'b00, quot}))
                    : (UW'(u_r) - $signed({2'b00, quot}));

  // bisection bracket update
  always_comb begin
    lo_n = lo_r;
    hi_n = hi_r;
    if (acc_r < t_r) lo_n = u_r;
    else hi_n = u_r;
  end

  always_comb begin
    case (cmd.res_mode)
      ece_pkg::RES_ACC: res_v = acc_r;
      ece_pkg::RES_OMA: res_v = ONE - acc_r;
      ece_pkg::RES_T:   res_v = t_r;
      default:          res_v = t_r;
    endcase
  end

  always_ff @(posedge clk) begin
    // request capture, inputs clamped to one
    if (cmd.load) begin
      t_r    <= rd_unit(progress);
      u_r    <= rd_unit(progress);
      mode_r <= mode;
      kind_r <= preset_kind;
      p1x_r  <= rd_unit(out_x);
      p1y_r  <= rd_unit(out_y);
      p2x_r  <= rd_unit(in_x);
      p2y_r  <= rd_unit(in_y);
    end
    if (cmd.mul_en) begin
      case (cmd.dst)
        ece_pkg::DST_A:   a_r <= prod;
        ece_pkg::DST_B:   b_r <= prod;
        ece_pkg::DST_C:   c_r <= prod;
        ece_pkg::DST_TMP: tmp_r <= prod;
        default: ;
      endcase
      if (cmd.acc_k != 3'd0)
        acc_r <= (cmd.acc_clr ? val_t'(0) : acc_r) + val_t'(cmd.acc_k) * prod;
    end
    if (cmd.dx_save) dx_r <= acc_r;
    if (cmd.div_start) sgn_r <= (err[VW-1] != dx_r[VW-1]);
    // Newton update with clamp to the unit interval
    if (cmd.u_upd) begin
      if (uw < 0) u_r <= '0;
      else if (uw > UW'(ONE)) u_r <= ONE;
      else u_r <= uw[VW-1:0];
    end
    if (cmd.bis_init) begin
      lo_r <= '0;
      hi_r <= ONE;
      u_r  <= ONE >>> 1;
    end
    if (cmd.bis_step) begin
      lo_r <= lo_n;
      hi_r <= hi_n;
      u_r  <= (lo_n + hi_n) >>> 1;
    end
  end

  val_t res_c;
  assign res_c = clamp1(res_v);

  always_ff @(posedge clk) begin
    if (cmd.out_load) eased_r <= res_c[F:0];
  end

  assign stat.mode      = mode_r;
  assign stat.kind      = kind_r;
  assign stat.t_lt_half = t_r < (ONE >>> 1);
  assign stat.dx_small  = mdx < VW'(DX_EPS_C);
  assign stat.res_big   = mr > VW'(RES_EPS_C);
  assign stat.div_done  = !div_busy;
  assign eased          = eased_r;
endmodule

/* rtl/core/ece_ctrl.sv */
`include "easing_curve_evaluator_defines.svh"
// sequencer: preset products, Newton iterations, bisection, final y(u)
module ece_ctrl #(
  parameter int NEWTON_STEPS = 6,
  parameter int BISECT_STEPS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ece_pkg::ece_stat_t stat,
  output ece_pkg::ece_cmd_t  cmd
);
  localparam int IW = $clog2(NEWTON_STEPS + 1);
  localparam int BW = $clog2(BISECT_STEPS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_PRE0  = 4'd2;
  localparam logic [3:0] S_PRE1  = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_POST  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [1:0] EV_NEWT = 2'd0;
  localparam logic [1:0] EV_CHK  = 2'd1;
  localparam logic [1:0] EV_BIS  = 2'd2;
  localparam logic [1:0] EV_Y    = 2'd3;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    ev_r, ev_nxt;
  logic [3:0]    ph_r, ph_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [BW-1:0] bc_r, bc_nxt;
  logic [1:0]    res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ev_nxt    = ev_r;
    ph_nxt    = ph_r;
    it_nxt    = it_r;
    bc_nxt    = bc_r;
    res_nxt   = res_r;
    cmd       = ece_pkg::CMD_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        ph_nxt = 4'd0;
        it_nxt = '0;
        ev_nxt = EV_NEWT;
        res_nxt = ece_pkg::RES_ACC;
        state_nxt = (stat.mode == ece_pkg::MODE_BEZIER) ? S_EVAL : S_PRE0;
      end
      // preset products
      S_PRE0: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_OUT;
        case (stat.kind)
          ece_pkg::PRESET_SMOOTH: begin
            cmd.sel_a = ece_pkg::SEL_T; cmd.sel_b = ece_pkg::SEL_T;
            cmd.dst = ece_pkg::DST_C; state_nxt = S_PRE1;
          end
          ece_pkg::PRESET_IN: begin
            cmd.sel_a = ece_pkg::SEL_T; cmd.sel_b = ece_pkg::SEL_T; cmd.acc_k = 3'd1;
          end
          ece_pkg::PRESET_OUT: begin
            cmd.sel_a = ece_pkg::SEL_INV; cmd.sel_b = ece_pkg::SEL_INV; cmd.acc_k = 3'd1;
            res_nxt = ece_pkg::RES_OMA;
          end
          ece_pkg::PRESET_INOUT: begin
            cmd.acc_k = 3'd2;
            if (stat.t_lt_half) begin
              cmd.sel_a = ece_pkg::SEL_T; cmd.sel_b = ece_pkg::SEL_T;
            end else begin
              cmd.sel_a = ece_pkg::SEL_INV; cmd.sel_b = ece_pkg::SEL_INV;
              res_nxt = ece_pkg::RES_OMA;
            end
          end
          default: begin
            cmd.mul_en = 1'b0;
            res_nxt = ece_pkg::RES_T;
          end
        endcase
      end
      S_PRE1: begin
        cmd.mul_en  = 1'b1;
        cmd.sel_a   = ece_pkg::SEL_C;
        cmd.sel_b   = ece_pkg::SEL_TM;
        cmd.acc_clr = 1'b1;
        cmd.acc_k   = 3'd1;
        state_nxt   = S_OUT;
      end
      // one curve evaluation, slope phases only for Newton
      S_EVAL: begin
        cmd         = ece_pkg::eval_cmd(ph_r);
        cmd.use_y   = (ev_r == EV_Y);
        cmd.dx_save = (ev_r == EV_NEWT) && (ph_r == 4'd6);
        if (ph_r == 4'd10) state_nxt = S_POST;
        else if (ph_r == 4'd2 && ev_r != EV_NEWT) ph_nxt = 4'd6;
        else ph_nxt = ph_r + 4'd1;
      end
      S_POST: begin
        ph_nxt    = 4'd0;
        state_nxt = S_EVAL;
        case (ev_r)
          EV_NEWT: begin
            if (stat.dx_small) ev_nxt = EV_CHK;
            else begin
              cmd.div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          EV_CHK: begin
            if (stat.res_big) begin
              cmd.bis_init = 1'b1;
              bc_nxt = '0;
              ev_nxt = EV_BIS;
            end else ev_nxt = EV_Y;
          end
          EV_BIS: begin
            cmd.bis_step = 1'b1;
            if (bc_r == BW'(BISECT_STEPS - 1)) ev_nxt = EV_Y;
            else bc_nxt = bc_r + 1'b1;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.u_upd = 1'b1;
        ph_nxt    = 4'd0;
        state_nxt = S_EVAL;
        if (it_r == IW'(NEWTON_STEPS - 1)) ev_nxt = EV_CHK;
        else it_nxt = it_r + 1'b1;
      end
      S_OUT: begin
        cmd.res_mode = res_r;
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ev_r        <= EV_NEWT;
      ph_r        <= '0;
      it_r        <= '0;
      bc_r        <= '0;
      res_r       <= ece_pkg::RES_ACC;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ev_r        <= ev_nxt;
      ph_r        <= ph_nxt;
      it_r        <= it_nxt;
      bc_r        <= bc_nxt;
      res_r       <= res_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `ECE_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `ECE_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.out_load, out_valid)
  `ECE_ASSERT_IMPL(a_one_unit, clk, rst_n, 1'b1,
                   $countones({cmd.load, cmd.div_start, cmd.u_upd, cmd.bis_init,
                               cmd.bis_step}) <= 1)
  `ECE_ASSERT_IMPL(a_div_done, clk, rst_n, state_r == S_UPD, stat.div_done)
endmodule

/* rtl/core/easing_curve_evaluator.sv */
// Easing curve evaluator.
// in_req carries one request: progress t (Q1.16 style, 1.0 = 2^FRACTION_BITS),
// mode, preset kind and two bezier control points. out_res returns one eased
// value per request, in order. Both use valid/ready; a request is taken on a
// rising edge with valid and ready high.
// Presets are computed from t directly. Bezier mode solves x(u) = t for u by
// Newton steps, each a curve and slope pass, the serial divider (one quotient
// bit per cycle) and the update; Newton stops early when the slope gets too
// small. A curve pass then checks the residual, and bisection runs only if it
// is still large; every bisection step is a curve pass on the single shared
// multiplier. A last pass on y gives the result y(u).
// One request is processed at a time; the next is taken in the cycle after the
// result is written. The result sits in an output register: a new request is
// taken while the previous result waits, and a stalled receiver holds the
// block only when the next result is ready to be written.
// Reset (rst_n low, synchronous) empties the output register and returns the
// sequencer to idle.
module easing_curve_evaluator #(
  parameter int FRACTION_BITS = 16,
  parameter int NEWTON_STEPS  = 6,
  parameter int BISECT_STEPS  = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  ece_in_if.sink    in_req,
  ece_out_if.source out_res
);
  ece_pkg::ece_cmd_t  cmd;
  ece_pkg::ece_stat_t stat;
  logic [FRACTION_BITS:0] eased;

  ece_ctrl #(.NEWTON_STEPS(NEWTON_STEPS), .BISECT_STEPS(BISECT_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ece_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .progress    (in_req.progress),
    .mode        (in_req.mode),
    .preset_kind (in_req.preset_kind),
    .out_x       (in_req.out_x),
    .out_y       (in_req.out_y),
    .in_x        (in_req.in_x),
    .in_y        (in_req.in_y),
    .eased       (eased)
  );

  assign out_res.eased = eased;
endmodule
